/* sv/dfr_pkg.sv */
// Package for the UART frame deframer.
// Holds shared constants, register indexes and command/state types; no dependencies.
package dfr_pkg;

	localparam int unsigned BUFFER_DEPTH = 64;
	localparam int unsigned QUEUE_DEPTH  = 4;

	localparam logic [7:0] HEAD_FIRST_RST  = 8'hAA;
	localparam logic [7:0] HEAD_SECOND_RST = 8'h55;
	localparam logic [7:0] TAIL_FIRST_RST  = 8'h0D;
	localparam logic [7:0] TAIL_SECOND_RST = 8'h0A;

	typedef enum logic [1:0] {
		REG_HEAD_FIRST  = 2'd0,
		REG_HEAD_SECOND = 2'd1,
		REG_TAIL_FIRST  = 2'd2,
		REG_TAIL_SECOND = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_STORE = 1'b0,
		CMD_EMIT  = 1'b1
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EMIT = 1'b1
	} back_state_t;

	// front-end frame tracking state
	typedef struct packed {
		logic header_seen;
		logic in_frame;
		logic trailer_armed;
	} front_flags_t;

endpackage

/* sv/uart_frame_deframer.sv */
// Top level of the UART frame deframer: front end, command queue, back end.
// Depends on dfr_pkg, dfr_front, dfr_fifo, dfr_back (and dfr_ram through it).
//
// Receives one byte per s_ transaction and delivers the payload of each frame that
// opens with the two header bytes and closes with the two trailer bytes, one m_
// transaction per payload byte (tlast on the final one, tuser flagging the single
// result of an empty frame). The front end takes a byte every cycle as long as the
// command queue (QUEUE_DEPTH = 4 entries) has room; each payload byte and each good
// trailer becomes one queued command. The back end writes a stored byte into the
// payload RAM and drains a completed frame from it through the registered RAM read
// at one result per cycle while m_tready stays high. It holds the queue while
// draining, and during that time the queue absorbs up to four further commands
// before s_tready drops. s_tready follows queue room only: while it is low every
// byte waits, including headers, idle bytes and trailer bytes that queue nothing.
// Payloads hold at most BUFFER_DEPTH - 1 bytes; a longer frame is dropped.
module uart_frame_deframer #(
	parameter int unsigned BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] payload_byte, [13:8] byte_index,
	                              // [19:14] frame_length, [23:20] zero
	output logic        m_tuser,  // empty_frame
	output logic        m_tlast   // last_of_frame
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);
	localparam int unsigned CMD_W = 1 + AW + 8;

	logic               q_full;
	logic               in_accept;
	logic               f_push;
	dfr_pkg::cmd_kind_t f_kind;
	logic [AW-1:0]      f_arg;
	logic [7:0]         f_byte;
	logic [CMD_W-1:0]   q_in;
	logic [CMD_W-1:0]   q_out;
	logic               q_valid;
	logic               q_ready;
	logic [7:0]         o_byte;
	logic [5:0]         o_index;
	logic [5:0]         o_length;

	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && s_tready;
	assign q_in      = {f_kind, f_arg, f_byte};

	dfr_front #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.rx_byte   (s_tdata),
		.cmd_push  (f_push),
		.cmd_kind  (f_kind),
		.cmd_arg   (f_arg),
		.cmd_byte  (f_byte)
	);

	dfr_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (dfr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (q_in),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_out)
	);

	dfr_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.cmd_kind   (dfr_pkg::cmd_kind_t'(q_out[CMD_W-1])),
		.cmd_arg    (q_out[CMD_W-2:8]),
		.cmd_byte   (q_out[7:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (o_byte),
		.out_index  (o_index),
		.out_length (o_length),
		.out_empty  (m_tuser),
		.out_last   (m_tlast)
	);

	assign m_tdata = {4'h0, o_length, o_index, o_byte};

`ifndef NO_ASSERTIONS
	// commands are only produced for accepted bytes, which needs queue room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full)
		else $error("command pushed into full queue");

	// an empty-frame result stands alone
	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata[19:8] == 12'h000))
		else $error("empty-frame result malformed");

	// payload results stay inside their frame
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[13:8] != m_tdata[19:14]))
		else $error("byte index reaches frame length");
`endif

endmodule

/* sv/dfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/dfr_fifo.sv */
// Small register-based command queue between deframer front and back.
// No dependencies.
module dfr_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/dfr_front.sv */
// Deframer front end: header/trailer tracking, config registers, command issue.
// Depends on dfr_pkg.
module dfr_front #(
	parameter int unsigned BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [7:0]                      cfg_data,
	input  logic                            in_accept,
	input  logic [7:0]                      rx_byte,
	output logic                            cmd_push,
	output dfr_pkg::cmd_kind_t              cmd_kind,
	output logic [$clog2(BUFFER_DEPTH)-1:0] cmd_arg,
	output logic [7:0]                      cmd_byte
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	logic [7:0]            head_first_q;
	logic [7:0]            head_second_q;
	logic [7:0]            tail_first_q;
	logic [7:0]            tail_second_q;
	dfr_pkg::front_flags_t flags_q;
	dfr_pkg::front_flags_t flags_d;
	logic [AW-1:0]         count_q;
	logic [AW-1:0]         count_d;

	always_comb begin
		flags_d  = flags_q;
		count_d  = count_q;
		cmd_push = 1'b0;
		cmd_kind = dfr_pkg::CMD_STORE;
		cmd_arg  = count_q;
		cmd_byte = rx_byte;
		if (in_accept) begin
			if (!flags_q.in_frame) begin
				if (rx_byte == head_first_q) begin
					flags_d.header_seen = 1'b1;
				end else if (rx_byte == head_second_q && flags_q.header_seen) begin
					flags_d.in_frame      = 1'b1;
					flags_d.trailer_armed = 1'b0;
					count_d               = '0;
				end else begin
					flags_d.header_seen = 1'b0;
				end
			end else if (flags_q.trailer_armed) begin
				flags_d.in_frame      = 1'b0;
				flags_d.trailer_armed = 1'b0;
				count_d               = '0;
				if (rx_byte == tail_second_q) begin
					cmd_push = 1'b1;
					cmd_kind = dfr_pkg::CMD_EMIT;
				end
			end else if (rx_byte == tail_first_q) begin
				flags_d.trailer_armed = 1'b1;
			end else if (count_q == AW'(BUFFER_DEPTH - 1)) begin
				// buffer full: frame dropped
				flags_d.in_frame = 1'b0;
				count_d          = '0;
			end else begin
				cmd_push = 1'b1;
				count_d  = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_first_q  <= dfr_pkg::HEAD_FIRST_RST;
			head_second_q <= dfr_pkg::HEAD_SECOND_RST;
			tail_first_q  <= dfr_pkg::TAIL_FIRST_RST;
			tail_second_q <= dfr_pkg::TAIL_SECOND_RST;
			flags_q       <= '0;
			count_q       <= '0;
		end else begin
			flags_q <= flags_d;
			count_q <= count_d;
			if (cfg_we) begin
				case (dfr_pkg::cfg_reg_t'(cfg_index))
					dfr_pkg::REG_HEAD_FIRST:  head_first_q  <= cfg_data;
					dfr_pkg::REG_HEAD_SECOND: head_second_q <= cfg_data;
					dfr_pkg::REG_TAIL_FIRST:  tail_first_q  <= cfg_data;
					dfr_pkg::REG_TAIL_SECOND: tail_second_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

/* sv/dfr_back.sv */
// Deframer back end: executes queued commands, writes payload RAM, drains frames.
// Depends on dfr_pkg and dfr_ram.
module dfr_back #(
	parameter int unsigned BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  dfr_pkg::cmd_kind_t              cmd_kind,
	input  logic [$clog2(BUFFER_DEPTH)-1:0] cmd_arg,
	input  logic [7:0]                      cmd_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic [5:0]                      out_index,
	output logic [5:0]                      out_length,
	output logic                            out_empty,
	output logic                            out_last
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);
	localparam int unsigned XW = (AW > 6) ? AW : 6;

	dfr_pkg::back_state_t state_q;
	dfr_pkg::back_state_t state_d;

	logic [AW-1:0] len_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] ld_idx_q;
	logic          rd_valid_s1;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic [5:0]    out_index_q;
	logic [5:0]    out_length_q;
	logic          out_empty_q;
	logic          out_last_q;

	logic          out_free;
	logic          ram_we;
	logic          ram_re;
	logic [7:0]    ram_rdata;
	logic          start_emit;
	logic          load_empty;
	logic          load_emit;
	logic          ld_last;
	logic [XW-1:0] ld_idx_x;
	logic [XW-1:0] len_x;

	assign out_free = !out_valid_q || out_ready;
	assign ld_last  = (ld_idx_q + 1'b1) == len_q;
	assign ld_idx_x = XW'(ld_idx_q);
	assign len_x    = XW'(len_q);

	always_comb begin
		cmd_ready  = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		start_emit = 1'b0;
		load_empty = 1'b0;
		load_emit  = 1'b0;
		case (state_q)
			dfr_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd_kind == dfr_pkg::CMD_STORE) begin
						cmd_ready = 1'b1;
						ram_we    = 1'b1;
					end else if (cmd_arg == '0) begin
						cmd_ready  = out_free;
						load_empty = out_free;
					end else begin
						cmd_ready  = 1'b1;
						start_emit = 1'b1;
					end
				end
			end
			dfr_pkg::BK_EMIT: begin
				load_emit = rd_valid_s1 && out_free;
				// next read may issue once the held read data is consumed
				ram_re    = (rd_idx_q != len_q) && (!rd_valid_s1 || load_emit);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dfr_pkg::BK_IDLE: begin
				if (start_emit) begin
					state_d = dfr_pkg::BK_EMIT;
				end
			end
			dfr_pkg::BK_EMIT: begin
				if (load_emit && ld_last) begin
					state_d = dfr_pkg::BK_IDLE;
				end
			end
			default: state_d = dfr_pkg::BK_IDLE;
		endcase
	end

	dfr_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd_arg),
		.wdata (cmd_byte),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfr_pkg::BK_IDLE;
			len_q       <= '0;
			rd_idx_q    <= '0;
			ld_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_emit) begin
				len_q    <= cmd_arg;
				rd_idx_q <= '0;
				ld_idx_q <= '0;
			end
			if (ram_re) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (load_emit) begin
				ld_idx_q <= ld_idx_q + 1'b1;
			end
			if (ram_re) begin
				rd_valid_s1 <= 1'b1;
			end else if (load_emit) begin
				rd_valid_s1 <= 1'b0;
			end
			if (load_emit || load_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_empty) begin
			out_byte_q   <= '0;
			out_index_q  <= '0;
			out_length_q <= '0;
			out_empty_q  <= 1'b1;
			out_last_q   <= 1'b1;
		end else if (load_emit) begin
			out_byte_q   <= ram_rdata;
			out_index_q  <= ld_idx_x[5:0];
			out_length_q <= len_x[5:0];
			out_empty_q  <= 1'b0;
			out_last_q   <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_index  = out_index_q;
	assign out_length = out_length_q;
	assign out_empty  = out_empty_q;
	assign out_last   = out_last_q;

endmodule

/* test/tb.sv */
// Testbench for uart_frame_deframer: sends framed and noisy byte streams under
// several header/trailer settings and checks every payload result against a model.
// Depends on dfr_pkg and the uart_frame_deframer RTL.
`timescale 1ns / 1ps

module tb;

	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] index;
		logic [5:0] length;
		logic       empty;
		logic       last;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// pending rx bytes and the payload results still owed by the block
	logic [7:0]  rx_pending[$];
	frame_byte_t frame_bytes_due[$];

	// shadow of the header/trailer registers
	logic [7:0] head_a = dfr_pkg::HEAD_FIRST_RST;
	logic [7:0] head_b = dfr_pkg::HEAD_SECOND_RST;
	logic [7:0] tail_a = dfr_pkg::TAIL_FIRST_RST;
	logic [7:0] tail_b = dfr_pkg::TAIL_SECOND_RST;

	// receiver state
	bit         hdr_mark;
	bit         framing;
	bit         tail_armed;
	int         pay_count;
	logic [7:0] pay_buf[dfr_pkg::BUFFER_DEPTH];

	bit steady = 1'b0;
	int mismatches = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int frames_done = 0;

	uart_frame_deframer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void close_frame();
		framing = 1'b0;
		tail_armed = 1'b0;
		pay_count = 0;
	endfunction

	// advance the receiver by one byte, queueing any payload results it releases
	function automatic void deframe_step(input logic [7:0] b);
		frame_byte_t fb;
		if (!framing) begin
			if (b == head_a) begin
				hdr_mark = 1'b1;
			end else if (b == head_b && hdr_mark) begin
				framing = 1'b1;
				tail_armed = 1'b0;
				pay_count = 0;
			end else begin
				hdr_mark = 1'b0;
			end
		end else if (tail_armed) begin
			if (b == tail_b) begin
				frames_done++;
				if (pay_count == 0) begin
					fb = '{data: 8'h00, index: 6'd0, length: 6'd0, empty: 1'b1, last: 1'b1};
					frame_bytes_due.push_back(fb);
				end
				for (int i = 0; i < pay_count; i++) begin
					fb.data   = pay_buf[i];
					fb.index  = 6'(i);
					fb.length = 6'(pay_count);
					fb.empty  = 1'b0;
					fb.last   = (i == pay_count - 1);
					frame_bytes_due.push_back(fb);
				end
			end
			close_frame();
		end else if (b == tail_a) begin
			tail_armed = 1'b1;
		end else begin
			pay_buf[pay_count] = b;
			pay_count++;
			// the byte that fills the buffer kills the frame
			if (pay_count >= dfr_pkg::BUFFER_DEPTH)
				close_frame();
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				deframe_step(s_tdata);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (rx_pending.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
					s_tdata  <= rx_pending.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		frame_byte_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (frame_bytes_due.size() == 0) begin
					$display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = frame_bytes_due.pop_front();
					if (m_tdata[7:0] !== want.data) begin
						$display("%0t: payload_byte expected %h actual %h",
							$time, want.data, m_tdata[7:0]);
						mismatches++;
					end
					if (m_tdata[13:8] !== want.index) begin
						$display("%0t: byte_index expected %0d actual %0d",
							$time, want.index, m_tdata[13:8]);
						mismatches++;
					end
					if (m_tdata[19:14] !== want.length) begin
						$display("%0t: frame_length expected %0d actual %0d",
							$time, want.length, m_tdata[19:14]);
						mismatches++;
					end
					if (m_tdata[23:20] !== 4'd0) begin
						$display("%0t: tdata pad expected 0 actual %h", $time, m_tdata[23:20]);
						mismatches++;
					end
					if (m_tuser !== want.empty) begin
						$display("%0t: empty_frame expected %b actual %b",
							$time, want.empty, m_tuser);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_of_frame expected %b actual %b",
							$time, want.last, m_tlast);
						mismatches++;
					end
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 17);
		end
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// hold off until every byte is taken and every result is back, then let
	// queued store commands settle
	task automatic wait_drained();
		do @(posedge clk);
		while (rx_pending.size() != 0 || s_tvalid || frame_bytes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input dfr_pkg::cfg_reg_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dfr_pkg::REG_HEAD_FIRST:  head_a = val;
			dfr_pkg::REG_HEAD_SECOND: head_b = val;
			dfr_pkg::REG_TAIL_FIRST:  tail_a = val;
			dfr_pkg::REG_TAIL_SECOND: tail_b = val;
			default: ;
		endcase
	endtask

	task automatic set_markers(input logic [7:0] h1, h2, t1, t2);
		write_reg(dfr_pkg::REG_HEAD_FIRST, h1);
		write_reg(dfr_pkg::REG_HEAD_SECOND, h2);
		write_reg(dfr_pkg::REG_TAIL_FIRST, t1);
		write_reg(dfr_pkg::REG_TAIL_SECOND, t2);
	endtask

	function automatic logic [7:0] pick_payload();
		logic [7:0] v;
		do v = 8'($urandom_range(255));
		while (v == tail_a);
		return v;
	endfunction

	// header (optionally only the second byte), payload, then a good or broken trailer
	function automatic void push_frame(input int len, input bit good, input bit full_hdr);
		logic [7:0] junk;
		if (full_hdr)
			rx_pending.push_back(head_a);
		rx_pending.push_back(head_b);
		for (int i = 0; i < len; i++)
			rx_pending.push_back(pick_payload());
		rx_pending.push_back(tail_a);
		if (good) begin
			rx_pending.push_back(tail_b);
		end else begin
			do junk = 8'($urandom_range(255));
			while (junk == tail_b);
			rx_pending.push_back(junk);
		end
	endfunction

	task automatic random_traffic(input int n_items);
		int sent;
		int r;
		int len;
		int n_noise;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			len = $urandom_range(6);
			if (r < 62) begin
				push_frame(len, 1'b1, 1'b1);
				sent += len + 4;
			end else if (r < 72) begin
				push_frame(len, 1'b0, 1'b1);
				sent += len + 4;
			end else if (r < 82) begin
				n_noise = $urandom_range(3, 1);
				for (int i = 0; i < n_noise; i++)
					rx_pending.push_back(8'($urandom_range(255)));
				sent += n_noise;
			end else if (r < 92) begin
				// relies on the header mark surviving the previous frame
				push_frame(len, 1'b1, 1'b0);
				sent += len + 3;
			end else begin
				len = $urandom_range(20, 40);
				push_frame(len, 1'b1, 1'b1);
				sent += len + 4;
			end
		end
	endtask

	initial begin
		hdr_mark = 1'b0;
		close_frame();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset markers AA 55 0D 0A
		rx_pending = '{8'hAA, 8'h55, 8'h0D, 8'h0A,
			8'h55, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0D, 8'h0A,
			8'h55, 8'h12, 8'h0D, 8'h33,
			8'h07, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'h0D, 8'h0A};
		wait_drained();

		// largest payload that fits, then one byte too many, with no idling
		steady <= 1'b1;
		push_frame(dfr_pkg::BUFFER_DEPTH - 1, 1'b1, 1'b1);
		rx_pending.push_back(8'h0D);
		push_frame(dfr_pkg::BUFFER_DEPTH, 1'b1, 1'b1);
		wait_drained();
		steady <= 1'b0;

		// extreme marker values
		set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
		rx_pending = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
		wait_drained();

		// equal header bytes never open a frame; equal trailer bytes
		set_markers(8'h3C, 8'h3C, 8'h7E, 8'h7E);
		rx_pending = '{8'h3C, 8'h3C, 8'h3C, 8'h41, 8'h7E, 8'h7E, 8'h3C, 8'h3C};
		wait_drained();

		set_markers(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		random_traffic(12);
		wait_drained();

		$display("Sent %0d rx bytes under four marker settings; %0d frames completed,",
			bytes_taken, frames_done);
		$display("%0d payload results checked, including full-buffer and empty frames.",
			results_seen);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/dfr_pkg.sv
sv/dfr_ram.sv
sv/dfr_fifo.sv
sv/dfr_front.sv
sv/dfr_back.sv
sv/uart_frame_deframer.sv
test/tb.sv
